// ===== rtl/reader_writer_lock_arbiter_top_defines.svh =====
// Assertion macros for the lock arbiter checker file rwla_props.sv.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef READER_WRITER_LOCK_ARBITER_TOP_DEFINES_SVH
`define READER_WRITER_LOCK_ARBITER_TOP_DEFINES_SVH

// same-cycle implication
`define RWLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwla check failed");

// next-cycle implication
`define RWLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwla check failed");

`endif

// ===== rtl/rwla_pkg.sv =====
// Package for the reader-writer lock arbiter: beat types, codes, defaults.
// No dependencies.
package rwla_pkg;

  localparam int WaitDepthDef = 16;
  localparam int MaxSharedDef = 255;
  localparam int MaxResults   = 16;

  typedef enum logic [2:0] {
    OP_ACQ_SH = 3'd0,
    OP_ACQ_EX = 3'd1,
    OP_REL_SH = 3'd2,
    OP_REL_EX = 3'd3,
    OP_TRY_SH = 3'd4,
    OP_TRY_EX = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    OC_GRANTED     = 3'd0,
    OC_QUEUED      = 3'd1,
    OC_TRY_FAIL    = 3'd2,
    OC_WOKEN       = 3'd3,
    OC_REL_FREE    = 3'd4,
    OC_REL_SHARED  = 3'd5,
    OC_REJ_FULL    = 3'd6,
    OC_BAD_RELEASE = 3'd7
  } outcome_e;

  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,
    MODE_SHARED = 2'd1,
    MODE_EXCL   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAKE = 2'b10
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] requester_id;
  } req_t;

  typedef struct packed {
    logic [7:0] grant_id;
    outcome_e   outcome;
    logic       exclusive;
    logic       last;
  } rsp_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] id;
  } cmd_t;

endpackage

// ===== rtl/rwla_front.sv =====
// Front end: takes request beats, drops undefined functions, and holds
// classified commands in a two-entry queue. Depends on rwla_pkg.
module rwla_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  rwla_pkg::req_t  req_i,
  output logic            cmd_valid_o,
  output rwla_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);

  rwla_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           store;
  logic           take;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign store       = push && !full && (req_i.func inside {[3'd0:3'd5]});
  assign take        = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = store ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, store} - {1'b0, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      slot_q[wr_ptr_q] <= '{op: rwla_pkg::op_e'(req_i.func), id: req_i.requester_id};
    end
  end

endmodule

// ===== rtl/rwla_back.sv =====
// Back end: lock state, wait queue memory and wake sequencer.
// Depends on rwla_pkg; fed by rwla_front, drains into rwla_rsp_fifo.
module rwla_back #(
  parameter int WAIT_DEPTH = rwla_pkg::WaitDepthDef,
  parameter int MAX_SHARED = rwla_pkg::MaxSharedDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  rwla_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  input  logic            rsp_full_i,
  output logic            rsp_push_o,
  output rwla_pkg::rsp_t  rsp_o
);

  localparam int AW = $clog2(WAIT_DEPTH);
  localparam int FW = $clog2(WAIT_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int HW = $clog2(MAX_SHARED + 1);
  localparam int NW = $clog2(rwla_pkg::MaxResults + 1);

  logic [8:0]        mem [WAIT_DEPTH];
  logic [8:0]        rd_q;

  rwla_pkg::state_e  st_q, st_d;
  rwla_pkg::mode_e   mode_q, mode_d;
  logic [HW-1:0]     holders_q, holders_d;
  logic [FW-1:0]     ew_q, ew_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     head_q, head_d;
  logic [NW-1:0]     n_q, n_d;
  logic [7:0]        pend_q, pend_d;

  logic              wr_en;
  logic [8:0]        wr_data;
  logic [SW-1:0]     tail_sum;
  logic [SW-1:0]     tail_wrap;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     head_inc;
  logic              go;
  logic              excl;
  logic              try_only;
  logic              grant_ok;
  logic              is_rel_sh;
  logic              rel_bad;
  logic [HW-1:0]     rel_base;
  logic              cont;

  assign go        = !rsp_full_i;
  assign tail_sum  = SW'(head_q) + SW'(fill_q);
  assign tail_wrap = (tail_sum >= SW'(WAIT_DEPTH)) ? tail_sum - SW'(WAIT_DEPTH) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];
  assign head_inc  = (head_q == AW'(WAIT_DEPTH - 1)) ? '0 : head_q + AW'(1);

  assign excl      = cmd_i.op inside {rwla_pkg::OP_ACQ_EX, rwla_pkg::OP_TRY_EX};
  assign try_only  = cmd_i.op inside {rwla_pkg::OP_TRY_SH, rwla_pkg::OP_TRY_EX};
  assign grant_ok  = excl ? (mode_q == rwla_pkg::MODE_FREE)
                          : (holders_q < HW'(MAX_SHARED)) &&
                            ((mode_q == rwla_pkg::MODE_FREE) ||
                             ((mode_q == rwla_pkg::MODE_SHARED) && (ew_q == '0)));
  assign is_rel_sh = (cmd_i.op == rwla_pkg::OP_REL_SH);
  assign rel_bad   = is_rel_sh ? ((mode_q != rwla_pkg::MODE_SHARED) || (holders_q == '0))
                               : (mode_q != rwla_pkg::MODE_EXCL);
  assign rel_base  = is_rel_sh ? holders_q - HW'(1) : holders_q;
  assign cont      = (fill_q != '0) && (n_q < NW'(rwla_pkg::MaxResults)) &&
                     (holders_q < HW'(MAX_SHARED)) && !rd_q[8];

  always_comb begin
    st_d       = st_q;
    mode_d     = mode_q;
    holders_d  = holders_q;
    ew_d       = ew_q;
    fill_d     = fill_q;
    head_d     = head_q;
    n_d        = n_q;
    pend_d     = pend_q;
    wr_en      = 1'b0;
    wr_data    = {excl, cmd_i.id};
    cmd_pop_o  = 1'b0;
    rsp_push_o = 1'b0;
    rsp_o      = '{grant_id: cmd_i.id, outcome: rwla_pkg::OC_GRANTED,
                   exclusive: excl, last: 1'b1};
    case (st_q)
      rwla_pkg::ST_IDLE: begin
        if (cmd_valid_i && go) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            rwla_pkg::OP_ACQ_SH, rwla_pkg::OP_ACQ_EX,
            rwla_pkg::OP_TRY_SH, rwla_pkg::OP_TRY_EX: begin
              rsp_push_o = 1'b1;
              if (grant_ok) begin
                mode_d = excl ? rwla_pkg::MODE_EXCL : rwla_pkg::MODE_SHARED;
                if (!excl) begin
                  holders_d = holders_q + HW'(1);
                end
              end else if (try_only) begin
                rsp_o.outcome = rwla_pkg::OC_TRY_FAIL;
              end else if (fill_q >= FW'(WAIT_DEPTH)) begin
                rsp_o.outcome = rwla_pkg::OC_REJ_FULL;
              end else begin
                wr_en         = 1'b1;
                fill_d        = fill_q + FW'(1);
                ew_d          = excl ? ew_q + FW'(1) : ew_q;
                rsp_o.outcome = rwla_pkg::OC_QUEUED;
              end
            end
            rwla_pkg::OP_REL_SH, rwla_pkg::OP_REL_EX: begin
              rsp_o.exclusive = !is_rel_sh;
              if (rel_bad) begin
                rsp_push_o    = 1'b1;
                rsp_o.outcome = rwla_pkg::OC_BAD_RELEASE;
              end else begin
                holders_d = rel_base;
                if (is_rel_sh && (rel_base != '0)) begin
                  rsp_push_o    = 1'b1;
                  rsp_o.outcome = rwla_pkg::OC_REL_SHARED;
                end else if ((fill_q == '0) ||
                             (!rd_q[8] && (rel_base >= HW'(MAX_SHARED)))) begin
                  mode_d        = rwla_pkg::MODE_FREE;
                  rsp_push_o    = 1'b1;
                  rsp_o.outcome = rwla_pkg::OC_REL_FREE;
                end else if (rd_q[8]) begin
                  mode_d     = rwla_pkg::MODE_EXCL;
                  head_d     = head_inc;
                  fill_d     = fill_q - FW'(1);
                  ew_d       = (ew_q != '0) ? ew_q - FW'(1) : ew_q;
                  rsp_push_o = 1'b1;
                  rsp_o      = '{grant_id: rd_q[7:0], outcome: rwla_pkg::OC_WOKEN,
                                 exclusive: 1'b1, last: 1'b1};
                end else begin
                  mode_d    = rwla_pkg::MODE_SHARED;
                  head_d    = head_inc;
                  fill_d    = fill_q - FW'(1);
                  holders_d = rel_base + HW'(1);
                  pend_d    = rd_q[7:0];
                  n_d       = NW'(1);
                  st_d      = rwla_pkg::ST_WAKE;
                end
              end
            end
            default: begin
              rsp_push_o = 1'b0;
            end
          endcase
        end
      end
      rwla_pkg::ST_WAKE: begin
        if (go) begin
          rsp_push_o = 1'b1;
          rsp_o      = '{grant_id: pend_q, outcome: rwla_pkg::OC_WOKEN,
                         exclusive: 1'b0, last: !cont};
          if (cont) begin
            head_d    = head_inc;
            fill_d    = fill_q - FW'(1);
            holders_d = holders_q + HW'(1);
            pend_d    = rd_q[7:0];
            n_d       = n_q + NW'(1);
          end else begin
            st_d = rwla_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        st_d = rwla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= rwla_pkg::ST_IDLE;
      mode_q    <= rwla_pkg::MODE_FREE;
      holders_q <= '0;
      ew_q      <= '0;
      fill_q    <= '0;
      head_q    <= '0;
      n_q       <= '0;
    end else begin
      st_q      <= st_d;
      mode_q    <= mode_d;
      holders_q <= holders_d;
      ew_q      <= ew_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      n_q       <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // head entry prefetch, write bypass when enqueueing into an empty queue
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail] <= wr_data;
    end
    if (wr_en && (tail == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[head_d];
    end
  end

endmodule

// ===== rtl/rwla_rsp_fifo.sv =====
// Two-entry result queue that decouples the back end from the consumer.
// Depends on rwla_pkg.
module rwla_rsp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rsp_push_i,
  input  rwla_pkg::rsp_t  rsp_i,
  output logic            rsp_full_o,
  output logic            empty,
  input  logic            pop,
  output rwla_pkg::rsp_t  rsp_o
);

  rwla_pkg::rsp_t slot_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           store;
  logic           take;

  assign rsp_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign rsp_o      = slot_q[rd_ptr_q];
  assign store      = rsp_push_i && !rsp_full_o;
  assign take       = pop && !empty;
  assign cnt_d      = cnt_q + {1'b0, store} - {1'b0, take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ store;
      rd_ptr_q <= rd_ptr_q ^ take;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      slot_q[wr_ptr_q] <= rsp_i;
    end
  end

endmodule

// ===== rtl/reader_writer_lock_arbiter_top.sv =====
// Top level of the reader-writer lock arbiter with writer preference.
// Depends on rwla_pkg, rwla_front, rwla_back and rwla_rsp_fifo.
//
//   channel   handshake     beat type        direction
//   request   push / full   rwla_pkg::req_t  in
//   result    empty / pop   rwla_pkg::rsp_t  out
//
// The back end handles an acquire or a non-waking release in its idle state;
// a release that wakes shared waiters moves to the wake state, which gives
// one grant per cycle from the wait queue memory read port while the result
// queue is not full. Undefined functions are dropped at the front. Either
// side may stall; two-entry queues sit on both sides of the back end. Reset
// is asynchronous, active low; the wait queue is not cleared.
module reader_writer_lock_arbiter_top #(
  parameter int WAIT_DEPTH = rwla_pkg::WaitDepthDef,
  parameter int MAX_SHARED = rwla_pkg::MaxSharedDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  rwla_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output rwla_pkg::rsp_t  rsp_o
);

  logic           cmd_valid;
  rwla_pkg::cmd_t cmd;
  logic           cmd_pop;
  logic           rsp_full;
  logic           rsp_push;
  rwla_pkg::rsp_t rsp;

  rwla_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rwla_back #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .MAX_SHARED (MAX_SHARED)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp)
  );

  rwla_rsp_fifo u_rsp_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rsp_push_i (rsp_push),
    .rsp_i      (rsp),
    .rsp_full_o (rsp_full),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== rtl/rwla_props.sv =====
// Port-level checks for the lock arbiter, bound to the top level.
// Depends on rwla_pkg and reader_writer_lock_arbiter_top_defines.svh.
`include "reader_writer_lock_arbiter_top_defines.svh"

module rwla_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input rwla_pkg::rsp_t rsp_o
);

  logic woken;
  logic burst_mid;

  assign woken     = !empty && (rsp_o.outcome == rwla_pkg::OC_WOKEN);
  assign burst_mid = woken && !rsp_o.last;

  `RWLA_ASSERT_NXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_o))
  `RWLA_ASSERT_NOW(a_single_last, !empty && !woken, rsp_o.last)
  `RWLA_ASSERT_NOW(a_excl_wake_last, woken && rsp_o.exclusive, rsp_o.last)
  `RWLA_ASSERT_NXT(a_burst_cont, pop && burst_mid, empty || (woken && !rsp_o.exclusive))

endmodule

bind reader_writer_lock_arbiter_top rwla_props u_props (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

// ===== bench/tb.sv =====
// Testbench for reader_writer_lock_arbiter_top: queued request beats in, result beats out.
// Depends on rwla_pkg and the arbiter RTL. A built-in lock predictor checks every
// result beat, with random idling on both sides and one long receiver hold-off.
module tb;
  import rwla_pkg::*;

  localparam int WAIT_DEPTH  = WaitDepthDef;
  localparam int MAX_SHARED  = MaxSharedDef;
  localparam int QW          = $clog2(WAIT_DEPTH);
  localparam int HOLD_CYCLES = 250;
  localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD_7 = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic full;
  req_t req_i  = '0;
  logic empty;
  logic pop    = 1'b0;
  rsp_t rsp_o;

  reader_writer_lock_arbiter_top #(
    .WAIT_DEPTH(WAIT_DEPTH),
    .MAX_SHARED(MAX_SHARED)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // lock predictor state
  mode_e            lk_mode;
  int unsigned      holders, excl_waiting, q_fill;
  logic [QW-1:0]    q_head;
  logic [8:0]       waiters [WAIT_DEPTH];
  rsp_t             step_out [$];
  rsp_t             grant_q [$];

  req_t             pending [$];
  int unsigned      n_planned = 0;
  int unsigned      n_sent = 0, n_checked = 0, n_woken = 0, n_full = 0, mism = 0;
  int unsigned      send_wait = 0, pop_wait = 0, gap_calls = 0;
  logic             calm = 1'b0;
  logic             hold_off = 1'b0;

  function automatic void lock_reset();
    lk_mode      = MODE_FREE;
    holders      = 0;
    excl_waiting = 0;
    q_fill       = 0;
    q_head       = '0;
    grant_q.delete();
  endfunction

  function automatic void lock_note(logic [7:0] id, outcome_e oc, logic ex);
    rsp_t e;
    e.grant_id  = id;
    e.outcome   = oc;
    e.exclusive = ex;
    e.last      = 1'b0;
    step_out.push_back(e);
  endfunction

  function automatic logic lock_can_grant(logic ex);
    if (ex) return lk_mode == MODE_FREE;
    if (holders >= MAX_SHARED) return 1'b0;
    if (lk_mode == MODE_FREE) return 1'b1;
    return lk_mode == MODE_SHARED && excl_waiting == 0;
  endfunction

  // lock just freed: hand it to the queue head or report it free
  function automatic void lock_free_or_wake(logic [7:0] id, logic ex);
    logic [8:0]  w;
    int unsigned n;
    n = 0;
    if (q_fill == 0) begin
      lk_mode = MODE_FREE;
      lock_note(id, OC_REL_FREE, ex);
      return;
    end
    w = waiters[q_head];
    if (w[8]) begin
      lk_mode = MODE_EXCL;
      q_head  = q_head + 1'b1;
      q_fill--;
      if (excl_waiting > 0) excl_waiting--;
      lock_note(w[7:0], OC_WOKEN, 1'b1);
      return;
    end
    lk_mode = MODE_SHARED;
    while (q_fill > 0 && n < MaxResults && holders < MAX_SHARED && !waiters[q_head][8]) begin
      w      = waiters[q_head];
      q_head = q_head + 1'b1;
      q_fill--;
      holders++;
      lock_note(w[7:0], OC_WOKEN, 1'b0);
      n++;
    end
    if (n == 0) begin
      lk_mode = MODE_FREE;
      lock_note(id, OC_REL_FREE, ex);
    end
  endfunction

  function automatic void lock_apply(req_t r);
    logic          ex;
    logic [QW-1:0] tail;
    rsp_t          e;
    case (r.func)
      OP_ACQ_SH, OP_ACQ_EX, OP_TRY_SH, OP_TRY_EX: begin
        ex = r.func[0];
        if (lock_can_grant(ex)) begin
          if (ex) begin
            lk_mode = MODE_EXCL;
          end else begin
            lk_mode = MODE_SHARED;
            holders++;
          end
          lock_note(r.requester_id, OC_GRANTED, ex);
        end else if (r.func[2]) begin
          lock_note(r.requester_id, OC_TRY_FAIL, ex);
        end else if (q_fill >= WAIT_DEPTH) begin
          lock_note(r.requester_id, OC_REJ_FULL, ex);
        end else begin
          tail          = q_head + QW'(q_fill);
          waiters[tail] = {ex, r.requester_id};
          q_fill++;
          if (ex) excl_waiting++;
          lock_note(r.requester_id, OC_QUEUED, ex);
        end
      end
      OP_REL_SH: begin
        if (lk_mode != MODE_SHARED || holders == 0) begin
          lock_note(r.requester_id, OC_BAD_RELEASE, 1'b0);
        end else begin
          holders--;
          if (holders != 0) lock_note(r.requester_id, OC_REL_SHARED, 1'b0);
          else lock_free_or_wake(r.requester_id, 1'b0);
        end
      end
      OP_REL_EX: begin
        if (lk_mode != MODE_EXCL) lock_note(r.requester_id, OC_BAD_RELEASE, 1'b1);
        else lock_free_or_wake(r.requester_id, 1'b1);
      end
      default: ;
    endcase
    while (step_out.size() != 0) begin
      e      = step_out.pop_front();
      e.last = (step_out.size() == 0);
      grant_q.push_back(e);
    end
  endfunction

  function automatic void queue_req(logic [2:0] func, logic [7:0] id);
    req_t r;
    r.func         = func;
    r.requester_id = id;
    pending.push_back(r);
    lock_apply(r);
    if (func <= OP_TRY_EX) n_planned++;
  endfunction

  function automatic logic [7:0] any_id();
    return 8'($urandom);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    gap_calls++;
    if (gap_calls % 64 == 0) calm = ($urandom_range(0, 2) == 0);
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_beat(rsp_t got);
    rsp_t want;
    n_checked++;
    if (got.outcome == OC_WOKEN) n_woken++;
    if (got.outcome == OC_REJ_FULL) n_full++;
    if (grant_q.size() == 0) begin
      mism++;
      if (mism <= 10)
        $display("unexpected beat: id %0d outcome %0d ex %0b last %0b",
                 got.grant_id, got.outcome, got.exclusive, got.last);
      return;
    end
    want = grant_q.pop_front();
    if (got.grant_id !== want.grant_id || got.outcome !== want.outcome ||
        got.exclusive !== want.exclusive || got.last !== want.last) begin
      mism++;
      if (mism <= 10)
        $display("mismatch (exp/got): id %0d/%0d outcome %0d/%0d ex %0b/%0b last %0b/%0b",
                 want.grant_id, got.grant_id, want.outcome, got.outcome,
                 want.exclusive, got.exclusive, want.last, got.last);
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        lock_apply(req_i);
        n_sent++;
      end
      if (send_wait != 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (pending.size() != 0) begin
        req_i     <= pending.pop_front();
        push      <= 1'b1;
        send_wait = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_beat(rsp_o);
        pop_wait = pick_gap();
      end
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= !hold_off;
      end
    end
  end

  // long receiver stall so the block backs up into full
  initial begin
    wait (rst_ni);
    wait (n_sent >= 120);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(8 * 600000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned roll, k;
    op_e         op;
    lock_reset();

    // directed
    queue_req(OP_TRY_EX, 8'd0);
    queue_req(OP_REL_EX, 8'd255);
    queue_req(OP_REL_SH, 8'hA5);
    queue_req(OP_REL_EX, 8'h5A);
    queue_req(OP_TRY_SH, 8'd255);
    queue_req(OP_TRY_EX, 8'd1);
    queue_req(OP_ACQ_SH, 8'd2);
    queue_req(OP_REL_EX, 8'd3);
    queue_req(OP_REL_SH, 8'd4);
    queue_req(OP_REL_SH, 8'd5);
    queue_req(OP_ACQ_EX, 8'h80);
    queue_req(OP_TRY_SH, 8'd6);
    queue_req(OP_ACQ_SH, 8'd7);
    queue_req(OP_ACQ_EX, 8'd8);
    queue_req(OP_ACQ_SH, 8'd9);
    queue_req(FUNC_RSVD_6, 8'hFF);
    queue_req(FUNC_RSVD_7, 8'h00);
    queue_req(OP_REL_EX, 8'd10);   // shared burst stops at the writer
    queue_req(OP_ACQ_SH, 8'd11);   // writer preference: queued
    queue_req(OP_TRY_SH, 8'd12);
    queue_req(OP_REL_SH, 8'd13);   // wakes the writer
    queue_req(OP_REL_EX, 8'd14);   // wakes two readers
    queue_req(OP_REL_SH, 8'd15);
    queue_req(OP_REL_SH, 8'd16);

    // random, state-aware
    n_planned = 0;
    while (n_planned < 210) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_req(3'($urandom_range(0, 7)), any_id());
      end else if (lk_mode == MODE_FREE && roll < 22) begin
        // writer holds, readers pile up, at times past queue depth
        queue_req(OP_ACQ_EX, any_id());
        k = $urandom_range(10, 18);
        repeat (k) queue_req(OP_ACQ_SH, any_id());
      end else begin
        roll = $urandom_range(0, 99);
        case (lk_mode)
          MODE_FREE:
            op = roll < 45 ? OP_ACQ_SH : roll < 75 ? OP_ACQ_EX : roll < 88 ? OP_TRY_SH : OP_TRY_EX;
          MODE_SHARED:
            op = (roll < 50 || q_fill > 12) ? OP_REL_SH : roll < 72 ? OP_ACQ_SH :
                 roll < 86 ? OP_ACQ_EX : roll < 93 ? OP_TRY_SH : OP_TRY_EX;
          default:
            op = (roll < 45 || q_fill > 12) ? OP_REL_EX : roll < 70 ? OP_ACQ_SH :
                 roll < 85 ? OP_ACQ_EX : roll < 93 ? OP_TRY_SH : OP_TRY_EX;
        endcase
        queue_req(op, any_id());
      end
    end

    // release whatever is still held
    while (lk_mode != MODE_FREE)
      queue_req(lk_mode == MODE_SHARED ? OP_REL_SH : OP_REL_EX, any_id());

    lock_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || push || grant_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d requests accepted, %0d result beats checked, %0d wake grants, %0d full rejects",
             n_sent, n_checked, n_woken, n_full);
    $display("random idling on both sides, one %0d-cycle receiver stall, %0d mismatches",
             HOLD_CYCLES, mism);
    if (mism == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rwla_pkg.sv
rtl/rwla_front.sv
rtl/rwla_back.sv
rtl/rwla_rsp_fifo.sv
rtl/reader_writer_lock_arbiter_top.sv
rtl/rwla_props.sv
bench/tb.sv
